// ----- hw/rtl/fcsg_pkg.sv -----
// shared types and constants for the filled circle span generator
// no dependencies; imported by the controller, the datapath and the top level
package fcsg_pkg;

    localparam int RADIUS_W       = 6;
    localparam int COLOUR_W       = 8;
    localparam int OUT_W          = 13;
    localparam int MAX_RESULTS    = 46;
    localparam int CNT_W          = 6;
    localparam int DEF_MAX_RADIUS = 63;
    localparam int DEF_COORD_BITS = 11;

    // decision recurrence constants
    localparam int D_INIT   = 3;
    localparam int D_INC_IN = 6;
    localparam int D_INC_DN = 10;

    typedef struct packed {
        logic load;
        logic step;
    } fcsg_cmd_t;

    typedef struct packed {
        logic last;
    } fcsg_status_t;

endpackage

// ----- hw/rtl/fcsg_ctrl.sv -----
// request sequencing for the filled circle span generator
// depends on fcsg_pkg; drives load/step commands into fcsg_dp
module fcsg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  fcsg_pkg::fcsg_status_t status,
    output fcsg_pkg::fcsg_cmd_t    cmd
);
    import fcsg_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;

    // output slot is free or being drained this cycle
    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (advance)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/fcsg_dp.sv -----
// octant walk datapath and result register for the filled circle span generator
// depends on fcsg_pkg; commanded by fcsg_ctrl
module fcsg_dp #(
    parameter int MAX_RADIUS = fcsg_pkg::DEF_MAX_RADIUS,
    parameter int COORD_BITS = fcsg_pkg::DEF_COORD_BITS
) (
    input  logic                                clk,
    input  fcsg_pkg::fcsg_cmd_t                 cmd,
    output fcsg_pkg::fcsg_status_t              status,
    input  logic [fcsg_pkg::RADIUS_W-1:0]       radius,
    input  logic [COORD_BITS-1:0]               centre_x,
    input  logic [COORD_BITS-1:0]               centre_y,
    input  logic [fcsg_pkg::COLOUR_W-1:0]       colour,
    output logic signed [fcsg_pkg::OUT_W-1:0]   outer_row_top,
    output logic signed [fcsg_pkg::OUT_W-1:0]   outer_row_bottom,
    output logic signed [fcsg_pkg::OUT_W-1:0]   outer_left,
    output logic signed [fcsg_pkg::OUT_W-1:0]   outer_right,
    output logic signed [fcsg_pkg::OUT_W-1:0]   inner_row_top,
    output logic signed [fcsg_pkg::OUT_W-1:0]   inner_row_bottom,
    output logic signed [fcsg_pkg::OUT_W-1:0]   inner_left,
    output logic signed [fcsg_pkg::OUT_W-1:0]   inner_right,
    output logic [fcsg_pkg::COLOUR_W-1:0]       span_colour,
    output logic                                last_step
);
    import fcsg_pkg::*;

    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int SW = (RW > RADIUS_W) ? RW : RADIUS_W;
    localparam int DW = RW + 4;

    logic [RW-1:0]           x_reg, y_reg;
    logic signed [DW-1:0]    d_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [OUT_W-1:0]        cx_reg, cy_reg;
    logic [COLOUR_W-1:0]     colour_reg;

    logic [SW-1:0]           rad_ext;
    logic [SW-1:0]           rad_sat;
    logic [RW-1:0]           y_init;
    logic signed [DW-1:0]    d_init;
    logic [OUT_W+COORD_BITS-1:0] cx_ext, cy_ext;

    logic [RW-1:0]           x_next, y_next;
    logic signed [DW-1:0]    d_next;
    logic signed [DW-1:0]    xs, ys;
    logic                    last;
    logic [OUT_W-1:0]        x13, y13;

    // request load: saturate radius, mask centre into the output field width
    assign rad_ext = SW'(radius);
    assign rad_sat = (rad_ext > SW'(MAX_RADIUS)) ? SW'(MAX_RADIUS) : rad_ext;
    assign y_init  = rad_sat[RW-1:0];
    assign d_init  = DW'(D_INIT) - $signed({{(DW-RW){1'b0}}, y_init} << 1);
    assign cx_ext  = (OUT_W+COORD_BITS)'(centre_x);
    assign cy_ext  = (OUT_W+COORD_BITS)'(centre_y);

    // one step of the midpoint decision recurrence
    assign xs = $signed({{(DW-RW){1'b0}}, x_reg});
    assign ys = $signed({{(DW-RW){1'b0}}, y_reg});

    always_comb
    begin
        x_next = x_reg + RW'(1);
        if (d_reg < 0)
        begin
            d_next = d_reg + (xs <<< 2) + DW'(D_INC_IN);
            y_next = y_reg;
        end
        else
        begin
            d_next = d_reg + ((xs - ys) <<< 2) + DW'(D_INC_DN);
            y_next = y_reg - RW'(1);
        end
        last = (x_reg == y_reg) || (x_next > y_next)
            || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
    end

    assign status.last = last;
    assign x13 = {{(OUT_W-RW){1'b0}}, x_reg};
    assign y13 = {{(OUT_W-RW){1'b0}}, y_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg      <= '0;
            y_reg      <= y_init;
            d_reg      <= d_init;
            cnt_reg    <= '0;
            cx_reg     <= cx_ext[OUT_W-1:0];
            cy_reg     <= cy_ext[OUT_W-1:0];
            colour_reg <= colour;
        end
        else if (cmd.step)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            d_reg   <= d_next;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            outer_row_top    <= cy_reg - y13;
            outer_row_bottom <= cy_reg + y13;
            outer_left       <= cx_reg - x13;
            outer_right      <= cx_reg + x13;
            inner_row_top    <= cy_reg - x13;
            inner_row_bottom <= cy_reg + x13;
            inner_left       <= cx_reg - y13;
            inner_right      <= cx_reg + y13;
            span_colour      <= colour_reg;
            last_step        <= last;
        end
    end

endmodule

// ----- hw/rtl/filled_circle_span_generator.sv -----
// Filled disk span generator: each request (radius, centre, colour) is walked
// over one octant of the midpoint circle, one octant point per clock unless
// out_stall holds the output, and each point gives one result of four horizontal
// spans; the final one has last_step set. A request is loaded, then walked over
// about radius/sqrt(2) + 1 points (45 at radius 63; one at radius zero) by the
// single decision-update unit that advances one point a cycle. in_stall stays
// high from acceptance until the last point enters the output register, and
// out_stall holds the walk in place.
// depends on fcsg_pkg, fcsg_ctrl and fcsg_dp
module filled_circle_span_generator #(
    parameter int MAX_RADIUS = fcsg_pkg::DEF_MAX_RADIUS,
    parameter int COORD_BITS = fcsg_pkg::DEF_COORD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fcsg_pkg::RADIUS_W-1:0]       radius,
    input  logic [COORD_BITS-1:0]               centre_x,
    input  logic [COORD_BITS-1:0]               centre_y,
    input  logic [fcsg_pkg::COLOUR_W-1:0]       colour,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [fcsg_pkg::OUT_W-1:0]   outer_row_top,
    output logic signed [fcsg_pkg::OUT_W-1:0]   outer_row_bottom,
    output logic signed [fcsg_pkg::OUT_W-1:0]   outer_left,
    output logic signed [fcsg_pkg::OUT_W-1:0]   outer_right,
    output logic signed [fcsg_pkg::OUT_W-1:0]   inner_row_top,
    output logic signed [fcsg_pkg::OUT_W-1:0]   inner_row_bottom,
    output logic signed [fcsg_pkg::OUT_W-1:0]   inner_left,
    output logic signed [fcsg_pkg::OUT_W-1:0]   inner_right,
    output logic [fcsg_pkg::COLOUR_W-1:0]       span_colour,
    output logic                                last_step
);
    import fcsg_pkg::*;

    fcsg_cmd_t    cmd;
    fcsg_status_t status;

    fcsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fcsg_dp #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk              (clk),
        .cmd              (cmd),
        .status           (status),
        .radius           (radius),
        .centre_x         (centre_x),
        .centre_y         (centre_y),
        .colour           (colour),
        .outer_row_top    (outer_row_top),
        .outer_row_bottom (outer_row_bottom),
        .outer_left       (outer_left),
        .outer_right      (outer_right),
        .inner_row_top    (inner_row_top),
        .inner_row_bottom (inner_row_bottom),
        .inner_left       (inner_left),
        .inner_right      (inner_right),
        .span_colour      (span_colour),
        .last_step        (last_step)
    );

endmodule
